@@ hdl/egw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egw_pkg
// Shared types and constants of the exp-Golomb NAL bit writer.
// ----------------------------------------------------------------------------
package egw_pkg;

  // command opcodes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EGOL  = 2'd1,
    OP_CLOSE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // emulation prevention and trailing bits
  localparam logic [7:0] EscByte  = 8'h03;
  localparam logic [7:0] StopByte = 8'h80;
  localparam logic [1:0] ZeroSat  = 2'd2;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage : egw_pkg
`default_nettype wire

@@ hdl/egw_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egw_fifo
// Small register queue between the command front end and the byte back end.
// ----------------------------------------------------------------------------
module egw_fifo
  import egw_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] pop_data_o,
  output q_stat_t               stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // pointer and fill count update
  always_comb begin
    do_push  = push_i && (cnt_q != CntW'(Depth));
    do_pop   = pop_i && (cnt_q != '0);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule : egw_fifo
`default_nettype wire

@@ hdl/egw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egw_front
// Accepts commands, forms the bit string and its length, queues the request.
// ----------------------------------------------------------------------------
module egw_front
  import egw_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic [1:0]                             opcode_i,
  input  wire logic [31:0]                            value_i,
  input  wire logic [5:0]                             bit_count_i,
  output logic                                        push_o,
  output logic [VALUE_BITS+$clog2(2*VALUE_BITS):0]    push_data_o,
  input  wire q_stat_t                                q_stat_i
);

  localparam int LenW = $clog2(2 * VALUE_BITS);

  logic                  s1_valid_q, s1_valid_d;
  op_e                   s1_op_q, s1_op_d;
  logic [VALUE_BITS-1:0] s1_val_q, s1_val_d;
  logic [LenW-1:0]       s1_cnt_q, s1_cnt_d;
  logic [LenW-1:0]       code_len;
  logic [LenW-1:0]       str_len;
  logic                  drop;
  logic                  s1_adv;
  logic                  in_fire;

  // stage 1: clip the count, form value plus one for the exp-Golomb code
  always_comb begin
    in_fire    = in_valid_i && in_ready_o;
    s1_valid_d = s1_valid_q;
    s1_op_d    = s1_op_q;
    s1_val_d   = s1_val_q;
    s1_cnt_d   = s1_cnt_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_fire) begin
      s1_op_d  = op_e'(opcode_i);
      s1_cnt_d = (bit_count_i > 6'(VALUE_BITS)) ? LenW'(VALUE_BITS) : LenW'(bit_count_i);
      unique case (op_e'(opcode_i))
        OP_WRITE: begin
          s1_valid_d = 1'b1;
          s1_val_d   = value_i[VALUE_BITS-1:0];
        end
        OP_EGOL: begin
          s1_valid_d = 1'b1;
          s1_val_d   = value_i[VALUE_BITS-1:0] + VALUE_BITS'(1);
        end
        OP_CLOSE: begin
          s1_valid_d = 1'b1;
          s1_val_d   = value_i[VALUE_BITS-1:0];
        end
        OP_NONE: begin
          s1_valid_d = 1'b0;
          s1_val_d   = s1_val_q;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  // stage 2: leading one of the code gives the string length
  always_comb begin
    code_len = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (s1_val_q[i]) begin
        code_len = LenW'(i + 1);
      end
    end
  end

  always_comb begin
    unique case (s1_op_q)
      OP_WRITE: str_len = s1_cnt_q;
      OP_EGOL:  str_len = (code_len == '0) ? '0 : LenW'({code_len, 1'b0} - 1);
      OP_CLOSE: str_len = '0;
      OP_NONE:  str_len = '0;
      default:  str_len = '0;
    endcase
    // empty strings give no bytes and are not queued
    drop        = s1_valid_q && (s1_op_q != OP_CLOSE) && (str_len == '0);
    s1_adv      = s1_valid_q && (drop || !q_stat_i.full);
    push_o      = s1_valid_q && !drop && !q_stat_i.full;
    push_data_o = {(s1_op_q == OP_CLOSE), s1_val_q, str_len};
    in_ready_o  = !s1_valid_q || s1_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q  <= s1_op_d;
    s1_val_q <= s1_val_d;
    s1_cnt_q <= s1_cnt_d;
  end

endmodule : egw_front
`default_nettype wire

@@ hdl/egw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// egw_back
// Packs queued bit strings into bytes and applies emulation prevention.
// ----------------------------------------------------------------------------
module egw_back
  import egw_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [VALUE_BITS+$clog2(2*VALUE_BITS):0] pop_data_i,
  input  wire q_stat_t                                q_stat_i,
  output logic                                        pop_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [7:0]                                  out_byte_o,
  output logic                                        is_escape_o,
  output logic                                        last_of_item_o,
  output logic                                        end_of_unit_o
);

  localparam int LenW = $clog2(2 * VALUE_BITS);

  // current request
  logic                  cur_valid_q, cur_valid_d;
  logic                  cur_close_q, cur_close_d;
  logic [VALUE_BITS-1:0] cur_word_q, cur_word_d;
  logic [LenW-1:0]       cur_rem_q, cur_rem_d;
  // stream state
  logic [7:0]            part_q, part_d;
  logic [2:0]            fill_q, fill_d;
  logic [1:0]            zrun_q, zrun_d;
  // output register and held data byte behind an escape
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  out_esc_q, out_esc_d;
  logic                  out_last_q, out_last_d;
  logic                  out_eou_q, out_eou_d;
  logic                  hold_valid_q, hold_valid_d;
  logic [7:0]            hold_byte_q, hold_byte_d;
  logic                  hold_last_q, hold_last_d;
  logic                  hold_eou_q, hold_eou_d;

  logic                  out_free, can_emit, step_go, cur_done;
  logic [3:0]            room, take, new_fill;
  logic [LenW-1:0]       shamt;
  logic [VALUE_BITS-1:0] shifted;
  logic [7:0]            mask, placed, full_byte;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic                  emit_last, emit_eou;
  logic [1:0]            zrun_tmp;

  // bit chunk that fits into the partial byte
  always_comb begin
    room      = 4'd8 - {1'b0, fill_q};
    take      = (cur_rem_q < LenW'(room)) ? 4'(cur_rem_q) : room;
    shamt     = cur_rem_q - LenW'(take);
    shifted   = cur_word_q >> shamt;
    mask      = 8'((9'd1 << take) - 9'd1);
    placed    = (shifted[7:0] & mask) << (room - take);
    new_fill  = {1'b0, fill_q} + take;
    full_byte = part_q | placed;
  end

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    can_emit = out_free && !hold_valid_q;
    step_go  = cur_valid_q && can_emit;

    cur_valid_d  = cur_valid_q;
    cur_close_d  = cur_close_q;
    cur_word_d   = cur_word_q;
    cur_rem_d    = cur_rem_q;
    part_d       = part_q;
    fill_d       = fill_q;
    zrun_d       = zrun_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_esc_d    = out_esc_q;
    out_last_d   = out_last_q;
    out_eou_d    = out_eou_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    hold_last_d  = hold_last_q;
    hold_eou_d   = hold_eou_q;
    cur_done     = 1'b0;
    emit         = 1'b0;
    emit_byte    = full_byte;
    emit_last    = 1'b0;
    emit_eou     = 1'b0;
    zrun_tmp     = zrun_q;

    // held data byte follows its escape
    if (hold_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_byte_d   = hold_byte_q;
      out_esc_d    = 1'b0;
      out_last_d   = hold_last_q;
      out_eou_d    = hold_eou_q;
      hold_valid_d = 1'b0;
    end

    // one packing step on the current request
    if (step_go) begin
      if (cur_close_q) begin
        emit      = 1'b1;
        emit_byte = (fill_q == '0) ? StopByte : (part_q | (StopByte >> fill_q));
        emit_last = 1'b1;
        emit_eou  = 1'b1;
        part_d    = '0;
        fill_d    = '0;
        cur_done  = 1'b1;
      end else begin
        cur_rem_d = cur_rem_q - LenW'(take);
        fill_d    = new_fill[2:0];
        cur_done  = (cur_rem_d == '0);
        if (new_fill == 4'd8) begin
          emit      = 1'b1;
          emit_last = (cur_rem_d < LenW'(8));
          part_d    = '0;
        end else begin
          part_d = full_byte;
        end
      end
    end

    // emulation prevention on a finished byte
    if (emit) begin
      out_valid_d = 1'b1;
      if ((zrun_q == ZeroSat) && (emit_byte <= EscByte)) begin
        out_byte_d   = EscByte;
        out_esc_d    = 1'b1;
        out_last_d   = 1'b0;
        out_eou_d    = 1'b0;
        hold_valid_d = 1'b1;
        hold_byte_d  = emit_byte;
        hold_last_d  = emit_last;
        hold_eou_d   = emit_eou;
        zrun_tmp     = '0;
      end else begin
        out_byte_d = emit_byte;
        out_esc_d  = 1'b0;
        out_last_d = emit_last;
        out_eou_d  = emit_eou;
      end
      if (emit_byte == '0) begin
        zrun_d = (zrun_tmp == ZeroSat) ? ZeroSat : zrun_tmp + 2'd1;
      end else begin
        zrun_d = '0;
      end
      if (emit_eou) begin
        zrun_d = '0;
      end
    end

    // fetch the next request
    pop_o = !q_stat_i.empty && (!cur_valid_q || (step_go && cur_done));
    if (pop_o) begin
      cur_valid_d = 1'b1;
      {cur_close_d, cur_word_d, cur_rem_d} = pop_data_i;
    end else if (step_go && cur_done) begin
      cur_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      part_q       <= '0;
      fill_q       <= '0;
      zrun_q       <= '0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      cur_valid_q  <= cur_valid_d;
      part_q       <= part_d;
      fill_q       <= fill_d;
      zrun_q       <= zrun_d;
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_close_q <= cur_close_d;
    cur_word_q  <= cur_word_d;
    cur_rem_q   <= cur_rem_d;
    out_byte_q  <= out_byte_d;
    out_esc_q   <= out_esc_d;
    out_last_q  <= out_last_d;
    out_eou_q   <= out_eou_d;
    hold_byte_q <= hold_byte_d;
    hold_last_q <= hold_last_d;
    hold_eou_q  <= hold_eou_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign is_escape_o    = out_esc_q;
  assign last_of_item_o = out_last_q;
  assign end_of_unit_o  = out_eou_q;

endmodule : egw_back
`default_nettype wire

@@ hdl/exp_golomb_nal_bit_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// exp_golomb_nal_bit_writer_core
// Bit writer for NAL units: fixed fields, exp-Golomb codes, close with
// trailing bits, and emulation prevention on every emitted byte.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (in_valid_i / in_ready_o): opcode_i, value_i, bit_count_i.
//   Byte channel (out_valid_o / out_ready_i): out_byte_o with is_escape_o,
//   last_of_item_o and end_of_unit_o flags. Commands that form no byte
//   (opcode 3, zero bit count, or exp-Golomb of the all-ones value) are
//   taken and leave no trace.
//   A command is taken into the front register; a byte that its first
//   packing step finishes then passes the queue write, the request register
//   and the output register before it is on the byte channel.
//   Throughput: one command per cycle enters while the 4-entry queue has
//   room; the back end packs up to 8 bits a cycle while the byte register
//   is free and no escaped byte is held, and each 0x03 escape holds the
//   packing while its data byte waits. The longest exp-Golomb code is 63
//   bits; a close is a single packing step.
//   The output byte register limits the rate to one byte per cycle.
//   Reset clears the partial byte, the fill count, the zero run and the
//   queue. A stalled receiver holds the byte register; the queue and the
//   front register keep taking commands until full.
// ----------------------------------------------------------------------------
module exp_golomb_nal_bit_writer_core
  import egw_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] value_i,
  input  wire logic [5:0]  bit_count_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             is_escape_o,
  output logic             last_of_item_o,
  output logic             end_of_unit_o
);

  localparam int LenW  = $clog2(2 * VALUE_BITS);
  localparam int EntW  = 1 + VALUE_BITS + LenW;
  localparam int QDepth = 4;

  logic            push;
  logic [EntW-1:0] push_data;
  logic            pop;
  logic [EntW-1:0] pop_data;
  q_stat_t         q_stat;

  // command front end
  egw_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .bit_count_i (bit_count_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_stat_i    (q_stat)
  );

  // request queue
  egw_fifo #(
    .Width(EntW),
    .Depth(QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // byte packer and emulation prevention
  egw_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_data_i     (pop_data),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_escape_o    (is_escape_o),
    .last_of_item_o (last_of_item_o),
    .end_of_unit_o  (end_of_unit_o)
  );

endmodule : exp_golomb_nal_bit_writer_core
`default_nettype wire

@@ tb/exp_golomb_nal_bit_writer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_golomb_nal_bit_writer_core_tb
// Drives fixed-field, exp-Golomb, close and unused commands into the NAL bit
// writer and compares every emitted byte, escape flag, item flag and unit flag
// with a bit-level packer kept in the bench. A short table of directed
// commands comes first, then weighted random traffic with idle and stall
// bursts on both channels.
// ----------------------------------------------------------------------------
module exp_golomb_nal_bit_writer_core_tb;
  import egw_pkg::*;

  localparam int NumDirected = 25;
  localparam int NumRandom   = 355;
  localparam int CalmFrom    = 300;
  localparam int QuietLimit  = 1000;
  localparam int TailCycles  = 20;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_BYTE
  } row_chk_e;

  typedef struct {
    op_e         op;
    logic [31:0] val;
    logic [5:0]  cnt;
    row_chk_e    chk;
    logic [7:0]  typed;
  } cmd_row_t;

  typedef struct {
    logic [7:0] data;
    logic       esc;
    logic       last;
    logic       eou;
  } nal_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  op_e         cmd_op = OP_NONE;
  logic [31:0] cmd_value = '0;
  logic [5:0]  cmd_count = '0;
  logic        byte_valid;
  logic        byte_ready = 1'b0;
  logic [7:0]  byte_data;
  logic        byte_esc;
  logic        byte_last;
  logic        byte_eou;

  // bench copy of the writer state
  logic [7:0]  partial_byte = '0;
  int          bits_filled = 0;
  int          zero_run = 0;

  nal_byte_t   new_bytes[$];
  nal_byte_t   pending_bytes[$];

  int          mismatches = 0;
  int          bytes_seen = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  logic        tx_gaps = 1'b1;
  logic        rx_stalls = 1'b1;

  cmd_row_t directed_rows [NumDirected] = '{
    '{OP_CLOSE, 32'h0000_0000, 6'd0,  CHK_BYTE, StopByte},
    '{OP_NONE,  32'hFFFF_FFFF, 6'd63, CHK_NONE, 8'h00},
    '{OP_WRITE, 32'hFFFF_FFFF, 6'd0,  CHK_NONE, 8'h00},
    '{OP_WRITE, 32'hFFFF_FFFF, 6'd8,  CHK_BYTE, 8'hFF},
    '{OP_EGOL,  32'hFFFF_FFFF, 6'd0,  CHK_NONE, 8'h00},
    '{OP_WRITE, 32'hFFFF_FFFF, 6'd63, CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd32, CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0001, 6'd8,  CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd16, CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0003, 6'd8,  CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd16, CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0004, 6'd8,  CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd16, CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd7,  CHK_PRED, 8'h00},
    '{OP_CLOSE, 32'h0000_0000, 6'd0,  CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0000, 6'd16, CHK_PRED, 8'h00},
    '{OP_CLOSE, 32'hFFFF_FFFF, 6'd63, CHK_PRED, 8'h00},
    '{OP_EGOL,  32'h0000_0000, 6'd0,  CHK_PRED, 8'h00},
    '{OP_EGOL,  32'hFFFF_FFFE, 6'd0,  CHK_PRED, 8'h00},
    '{OP_WRITE, 32'h0000_0005, 6'd33, CHK_PRED, 8'h00},
    '{OP_EGOL,  32'h7FFF_FFFF, 6'd0,  CHK_PRED, 8'h00},
    '{OP_CLOSE, 32'h0000_0000, 6'd0,  CHK_PRED, 8'h00},
    '{OP_EGOL,  32'h0000_0006, 6'd0,  CHK_PRED, 8'h00},
    '{OP_NONE,  32'h0000_0000, 6'd0,  CHK_PRED, 8'h00},
    '{OP_CLOSE, 32'h0000_0000, 6'd0,  CHK_PRED, 8'h00}
  };

  exp_golomb_nal_bit_writer_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (cmd_valid),
    .in_ready_o     (cmd_ready),
    .opcode_i       (cmd_op),
    .value_i        (cmd_value),
    .bit_count_i    (cmd_count),
    .out_valid_o    (byte_valid),
    .out_ready_i    (byte_ready),
    .out_byte_o     (byte_data),
    .is_escape_o    (byte_esc),
    .last_of_item_o (byte_last),
    .end_of_unit_o  (byte_eou)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // emulation prevention on a finished byte
  function automatic void emit_escaped(input logic [7:0] b);
    nal_byte_t nb;
    nal_byte_t eb;
    nb = '{data: b, esc: 1'b0, last: 1'b0, eou: 1'b0};
    eb = '{data: EscByte, esc: 1'b1, last: 1'b0, eou: 1'b0};
    if (zero_run >= 2 && b <= EscByte) begin
      new_bytes.insert(new_bytes.size(), eb);
      zero_run = 0;
    end
    new_bytes.insert(new_bytes.size(), nb);
    if (b == 8'h00) begin
      if (zero_run < 2) zero_run++;
    end else begin
      zero_run = 0;
    end
  endfunction

  // place n bits of v msb first
  function automatic void put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      partial_byte[7 - bits_filled] = v[i];
      bits_filled++;
      if (bits_filled == 8) begin
        emit_escaped(partial_byte);
        partial_byte = '0;
        bits_filled = 0;
      end
    end
  endfunction

  // bytes one command forms, left in new_bytes with their flags
  function automatic void pack_command(input op_e op, input logic [31:0] val,
                                       input logic [5:0] cnt);
    logic [31:0] code;
    logic [7:0]  closing;
    nal_byte_t   tail;
    int          len;
    new_bytes.delete();
    case (op)
      OP_WRITE: begin
        put_bits(val, (cnt > 6'd32) ? 32 : int'(cnt));
      end
      OP_EGOL: begin
        code = val + 32'd1;
        len = 0;
        for (int i = 0; i < 32; i++) if (code[i]) len = i + 1;
        if (len > 0) begin
          put_bits(32'd0, len - 1);
          put_bits(code, len);
        end
      end
      OP_CLOSE: begin
        closing = (bits_filled == 0) ? StopByte : (partial_byte | (8'h80 >> bits_filled));
        emit_escaped(closing);
        partial_byte = '0;
        bits_filled = 0;
        zero_run = 0;
      end
      default: begin
      end
    endcase
    if (new_bytes.size() > 0) begin
      tail = new_bytes[new_bytes.size() - 1];
      tail.last = 1'b1;
      tail.eou = (op == OP_CLOSE);
      new_bytes[new_bytes.size() - 1] = tail;
    end
  endfunction

  // hand one request to the block and record the bytes it must form
  task automatic issue_cmd(input op_e op, input logic [31:0] val, input logic [5:0] cnt,
                           input row_chk_e chk, input logic [7:0] typed);
    nal_byte_t nb;
    cmd_valid <= 1'b1;
    cmd_op    <= op;
    cmd_value <= val;
    cmd_count <= cnt;
    do @(posedge clk); while (!cmd_ready);
    pack_command(op, val, cnt);
    if (chk == CHK_NONE) begin
      new_bytes.delete();
    end else if (chk == CHK_BYTE) begin
      nb = '{data: typed, esc: 1'b0, last: 1'b1, eou: (op == OP_CLOSE)};
      new_bytes.delete();
      new_bytes.insert(0, nb);
    end
    foreach (new_bytes[i]) pending_bytes.insert(pending_bytes.size(), new_bytes[i]);
  endtask

  // optional gap on the request side
  task automatic maybe_gap();
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // hold requests back until every expected byte has come out
  task automatic drain_bytes();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic note_mismatch(input string field, input logic [7:0] got,
                               input logic [7:0] want);
    $display("byte %0d: %s is %0h, expected %0h", bytes_seen, field, got, want);
    mismatches++;
  endtask

  // random request weighted toward zero runs and short codes
  task automatic random_cmd();
    op_e         op;
    logic [31:0] val;
    logic [5:0]  cnt;
    int          r;
    r = $urandom_range(0, 99);
    val = $urandom;
    cnt = 6'($urandom_range(0, 63));
    if (r < 45) begin
      op = OP_WRITE;
      r = $urandom_range(0, 9);
      if (r < 7) cnt = 6'($urandom_range(0, 12));
      else if (r < 9) cnt = 6'($urandom_range(16, 32));
      r = $urandom_range(0, 99);
      if (r < 30) val = 32'd0;
      else if (r < 45) val = $urandom_range(0, 3);
    end else if (r < 78) begin
      op = OP_EGOL;
      r = $urandom_range(0, 19);
      if (r < 10) val = $urandom_range(0, 30);
      else if (r < 15) val = $urandom_range(0, 65535);
      else if (r < 17) val = 32'hFFFF_FFFF - $urandom_range(0, 3);
    end else if (r < 92) begin
      op = OP_CLOSE;
    end else begin
      op = OP_NONE;
    end
    issue_cmd(op, val, cnt, CHK_PRED, 8'h00);
  endtask

  // receiver with stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      byte_ready <= 1'b0;
      stall_left--;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      byte_ready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      byte_ready <= 1'b1;
    end
  end

  // byte checker
  always @(posedge clk) begin
    if (rst_n && byte_valid && byte_ready) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("unexpected byte", byte_data, 8'h00);
      end else begin
        if (byte_data !== pending_bytes[0].data)
          note_mismatch("data", byte_data, pending_bytes[0].data);
        if (byte_esc !== pending_bytes[0].esc)
          note_mismatch("escape", 8'(byte_esc), 8'(pending_bytes[0].esc));
        if (byte_last !== pending_bytes[0].last)
          note_mismatch("last", 8'(byte_last), 8'(pending_bytes[0].last));
        if (byte_eou !== pending_bytes[0].eou)
          note_mismatch("end of unit", 8'(byte_eou), 8'(pending_bytes[0].eou));
        void'(pending_bytes.pop_front());
      end
      bytes_seen++;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_valid && cmd_ready) || (byte_valid && byte_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      maybe_gap();
      issue_cmd(directed_rows[i].op, directed_rows[i].val, directed_rows[i].cnt,
                directed_rows[i].chk, directed_rows[i].typed);
    end
    drain_bytes();

    // random traffic in stretches of differing pressure
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 40 == 0) begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_stalls = ($urandom_range(0, 2) != 0);
      end
      if (i >= CalmFrom) begin
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
      end
      if (i == NumRandom / 2) drain_bytes();
      maybe_gap();
      random_cmd();
    end

    drain_bytes();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
